>>> src/pose_int_pkg.sv
// constants, types and the quarter-wave sine table of the pose integrator
`default_nettype none

package pose_int_pkg;

  localparam int STEP_W = 24;
  localparam int POS_W = 32;
  localparam int HEAD_W = 16;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SINE_W = 17;
  localparam int TRIG_FRAC = 16;
  localparam int QUARTER_W = 14;

  localparam int TRIG_S_W = SINE_W + 1;
  localparam int PROD_W = STEP_W + TRIG_S_W;
  localparam int DOT_W = PROD_W + 1;
  localparam int VEL_W = DOT_W - TRIG_FRAC;
  localparam int ACC_W = POS_W + 1;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [SINE_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic                  neg;
    logic [SINE_IDX_W-1:0] idx;
  } trig_addr_t;

  // taylor series in q30, rounded to q16
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (PI_Q30 * 64'(i)) / 64'(2 * SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      term = x;
      sum = signed'(x);
      // terms up to x^21, each divided by (2k)(2k+1), signs alternating
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd272;
      sum = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd342;
      sum = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd420;
      sum = sum + signed'(term);
      if (sum < 0) begin
        sum = '0;
      end
      tab[i] = SINE_W'((unsigned'(sum) + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // binary angle to table index and sign of the sine
  function automatic trig_addr_t trig_addr(input logic [HEAD_W-1:0] u);
    trig_addr_t                 a;
    logic [1:0]                 quad;
    logic [QUARTER_W:0]         r;
    logic [31:0]                scaled;
    quad = u[HEAD_W-1 -: 2];
    r = {1'b0, u[QUARTER_W-1:0]};
    if (quad[0]) begin
      r = (QUARTER_W + 1)'(1 << QUARTER_W) - r;
    end
    scaled = 32'(r) * 32'(SINE_TABLE_DEPTH) + 32'(1 << (QUARTER_W - 1));
    a.idx = scaled[SINE_IDX_W+QUARTER_W-1:QUARTER_W];
    a.neg = quad[1];
    return a;
  endfunction

endpackage

`default_nettype wire

>>> src/pose_int_if.sv
// valid/ready channels for steps in and poses out
`default_nettype none

interface pose_int_step_if;
  import pose_int_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [STEP_W-1:0] step_x;
  logic signed [STEP_W-1:0] step_y;
  logic signed [HEAD_W-1:0] step_heading;

  modport source (output valid, mode, step_x, step_y, step_heading, input ready);
  modport sink (input valid, mode, step_x, step_y, step_heading, output ready);
endinterface

interface pose_int_pose_if;
  import pose_int_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pose_x;
  logic signed [POS_W-1:0]  pose_y;
  logic signed [HEAD_W-1:0] pose_heading;
  logic                     saturated;

  modport source (output valid, pose_x, pose_y, pose_heading, saturated, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, saturated, output ready);
endinterface

`default_nettype wire

>>> src/pose_integrator.sv
// Dead-reckoning pose integrator. Each step word is either a robot-frame
// step, rotated by the heading held before it and added with saturation to
// the world position, or a load of an absolute pose; one pose word comes out
// for every step word. A new word is taken every cycle unless the pipeline
// is stalled by the pose output. The word passes through registered stages
// in order: the sine rom is read with registered data at the edge that takes
// the word, then the four rotation products, then the sums with rounding,
// then the saturating add into the position registers, with separate output
// registers loaded alongside them. The heading is updated as the word is taken, so the rom
// address of the next word is ready at once. Every stage holds when the one
// after it is full and stalled.
`default_nettype none

module pose_integrator
  import pose_int_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  pose_int_step_if.sink    step,
  pose_int_pose_if.source  pose
);

  logic [HEAD_W-1:0] world_heading;
  logic signed [POS_W-1:0] world_x;
  logic signed [POS_W-1:0] world_y;

  logic v1, v2, v3, ov;
  logic en1, en2, en3, adv_out;

  trig_addr_t sin_addr, cos_addr;

  // stage 1
  logic [SINE_W-1:0]        s1_sin_mag, s1_cos_mag;
  logic                     s1_sin_neg, s1_cos_neg;
  logic                     s1_mode;
  logic signed [STEP_W-1:0] s1_x, s1_y;
  logic [HEAD_W-1:0]        s1_head;

  // stage 2
  logic signed [TRIG_S_W-1:0] sin_v, cos_v;
  logic signed [PROD_W-1:0]   p_xc, p_ys, p_xs, p_yc;
  logic                       s2_mode;
  logic signed [STEP_W-1:0]   s2_x, s2_y;
  logic [HEAD_W-1:0]          s2_head;

  // stage 3
  logic signed [DOT_W-1:0]  dot_x, dot_y;
  logic signed [VEL_W-1:0]  s3_vx, s3_vy;
  logic                     s3_mode;
  logic signed [STEP_W-1:0] s3_x, s3_y;
  logic [HEAD_W-1:0]        s3_head;

  // output stage
  logic signed [ACC_W-1:0] sum_x, sum_y;
  logic signed [POS_W-1:0] world_x_next, world_y_next;
  logic                    clip_x, clip_y;
  logic signed [POS_W-1:0] out_x, out_y;
  logic [HEAD_W-1:0]       out_head;
  logic                    out_sat;

  assign adv_out = v3 && (!ov || pose.ready);
  assign en3 = !v3 || adv_out;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign step.ready = en1;

  assign sin_addr = trig_addr(world_heading);
  assign cos_addr = trig_addr(world_heading + HEAD_W'(1 << QUARTER_W));

  // valid bits and heading
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
      world_heading <= '0;
    end else begin
      if (en1) begin
        v1 <= step.valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (adv_out) begin
        ov <= 1'b1;
      end else if (pose.ready) begin
        ov <= 1'b0;
      end
      if (step.valid && en1) begin
        world_heading <= step.mode ? unsigned'(step.step_heading)
                                   : world_heading + unsigned'(step.step_heading);
      end
    end
  end

  // stage 1: sine rom, two read ports with registered data, at the pre-step heading
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sin_mag <= SINE_TAB[sin_addr.idx];
      s1_cos_mag <= SINE_TAB[cos_addr.idx];
      s1_sin_neg <= sin_addr.neg;
      s1_cos_neg <= cos_addr.neg;
      s1_mode <= step.mode;
      s1_x <= step.step_x;
      s1_y <= step.step_y;
      s1_head <= step.mode ? unsigned'(step.step_heading)
                           : world_heading + unsigned'(step.step_heading);
    end
  end

  // stage 2: rotation products
  assign sin_v = s1_sin_neg ? -signed'({1'b0, s1_sin_mag}) : signed'({1'b0, s1_sin_mag});
  assign cos_v = s1_cos_neg ? -signed'({1'b0, s1_cos_mag}) : signed'({1'b0, s1_cos_mag});

  always_ff @(posedge clk) begin
    if (en2) begin
      p_xc <= PROD_W'(s1_x) * PROD_W'(cos_v);
      p_ys <= PROD_W'(s1_y) * PROD_W'(sin_v);
      p_xs <= PROD_W'(s1_x) * PROD_W'(sin_v);
      p_yc <= PROD_W'(s1_y) * PROD_W'(cos_v);
      s2_mode <= s1_mode;
      s2_x <= s1_x;
      s2_y <= s1_y;
      s2_head <= s1_head;
    end
  end

  // stage 3: round half up, floor shift
  assign dot_x = DOT_W'(p_xc) - DOT_W'(p_ys) + DOT_W'(1 << (TRIG_FRAC - 1));
  assign dot_y = DOT_W'(p_xs) + DOT_W'(p_yc) + DOT_W'(1 << (TRIG_FRAC - 1));

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_vx <= dot_x[DOT_W-1:TRIG_FRAC];
      s3_vy <= dot_y[DOT_W-1:TRIG_FRAC];
      s3_mode <= s2_mode;
      s3_x <= s2_x;
      s3_y <= s2_y;
      s3_head <= s2_head;
    end
  end

  // saturating accumulate
  assign sum_x = ACC_W'(world_x) + ACC_W'(s3_vx);
  assign sum_y = ACC_W'(world_y) + ACC_W'(s3_vy);
  assign clip_x = sum_x[ACC_W-1] != sum_x[ACC_W-2];
  assign clip_y = sum_y[ACC_W-1] != sum_y[ACC_W-2];

  always_comb begin
    if (s3_mode) begin
      world_x_next = POS_W'(s3_x);
      world_y_next = POS_W'(s3_y);
    end else begin
      if (clip_x) begin
        world_x_next = {sum_x[ACC_W-1], {(POS_W - 1){!sum_x[ACC_W-1]}}};
      end else begin
        world_x_next = sum_x[POS_W-1:0];
      end
      if (clip_y) begin
        world_y_next = {sum_y[ACC_W-1], {(POS_W - 1){!sum_y[ACC_W-1]}}};
      end else begin
        world_y_next = sum_y[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      world_x <= '0;
      world_y <= '0;
    end else if (adv_out) begin
      world_x <= world_x_next;
      world_y <= world_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_x <= world_x_next;
      out_y <= world_y_next;
      out_head <= s3_head;
      out_sat <= !s3_mode && (clip_x || clip_y);
    end
  end

  assign pose.valid = ov;
  assign pose.pose_x = out_x;
  assign pose.pose_y = out_y;
  assign pose.pose_heading = signed'(out_head);
  assign pose.saturated = out_sat;

endmodule

`default_nettype wire
